### src/tpsd_pkg.sv
// Shared types, constants and translation functions for the pattern stream decoder.
package tpsd_pkg;

    localparam int HighestNote = 120;
    localparam logic [6:0] KEY_OFF_CODE = 7'd121;
    localparam logic [0:0] CFG_PATTERN_COUNT = 1'b0;
    localparam logic [0:0] CFG_DISABLED_MASK = 1'b1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    localparam logic [7:0] CMD_SPEED_EXT = 8'h0e;
    localparam logic [7:0] CMD_SET_TEMPO = 8'h0f;
    localparam logic [7:0] CMD_NSLIDE_UP = 8'h14;
    localparam logic [7:0] CMD_NSLIDE_DN = 8'h15;
    localparam logic [7:0] CMD_HALVE = 8'h16;
    localparam logic [7:0] CMD_SAMPLE_OFS = 8'h18;
    localparam logic [7:0] CMD_DOUBLE = 8'h1f;
    localparam logic [7:0] CMD_EXTENDED = 8'h21;
    localparam logic [7:0] CMD_SET_VOL = 8'h0c;
    localparam logic [7:0] CMD_PAN = 8'h0a;
    localparam logic [4:0] CODE_SET_VOLUME = 5'd12;

    // Entry gathered by the front end, ready for translation
    typedef struct packed {
        logic [15:0] pattern_index;
        logic [15:0] row_index;
        logic [7:0]  mask;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [7:0]  b5;
    } entry_t;

    typedef struct packed {
        logic [15:0] pattern_index;
        logic [15:0] row_index;
        logic [4:0]  channel_index;
        logic [6:0]  note_code;
        logic [7:0]  instrument_number;
        logic [1:0]  volume_kind;
        logic [7:0]  volume_value;
        logic [4:0]  effect_code;
        logic [7:0]  effect_param;
        logic        effect_dropped;
    } cell_t;

    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_HDR2 = 5'b00100,
        PH_HDR3 = 5'b01000,
        PH_BODY = 5'b10000
    } phase_t;

    function automatic logic [4:0] dense_code(input logic [7:0] raw);
        logic [4:0] c;
        case (raw)
            8'h00: c = 5'd0;  8'h01: c = 5'd1;  8'h02: c = 5'd2;  8'h03: c = 5'd3;
            8'h04: c = 5'd4;  8'h05: c = 5'd5;  8'h06: c = 5'd6;  8'h07: c = 5'd7;
            8'h08: c = 5'd8;  8'h09: c = 5'd9;  8'h0a: c = 5'd10; 8'h0b: c = 5'd11;
            8'h0c: c = 5'd12; 8'h0d: c = 5'd13; 8'h0e: c = 5'd13; 8'h0f: c = 5'd14;
            8'h10: c = 5'd15; 8'h11: c = 5'd16; 8'h12: c = 5'd17; 8'h13: c = 5'd18;
            8'h14: c = 5'd17; 8'h15: c = 5'd18; 8'h16: c = 5'd19; 8'h17: c = 5'd0;
            8'h18: c = 5'd20; 8'h19: c = 5'd0;  8'h1a: c = 5'd21; 8'h1b: c = 5'd22;
            8'h1c: c = 5'd23; 8'h1d: c = 5'd24; 8'h1e: c = 5'd25; 8'h1f: c = 5'd26;
            8'h20: c = 5'd27; 8'h21: c = 5'd14;
            default: c = 5'd0;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] payload_len(input logic [7:0] m);
        logic [2:0] n;
        n = m[5] ? 3'd2 : 3'd0;
        if (m[7] && m[6]) n = n + 3'd4;
        else if (m[7] || m[6]) n = n + 3'd2;
        return n;
    endfunction

endpackage

### src/tpsd_front.sv
// Front end: walks the byte stream and gathers complete channel entries.
module tpsd_front
    import tpsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  data_byte,
    input  logic [15:0] pattern_count,
    input  logic [31:0] disabled_channel_mask,
    output logic        entry_valid,
    output entry_t      entry
);

    phase_t      phase_reg, phase_next;
    logic [15:0] rows_reg, rows_next;
    logic [15:0] row_reg, row_next;
    logic [15:0] pat_reg, pat_next;
    logic [7:0]  mask_reg, mask_next;
    logic [2:0]  held_cnt_reg, held_cnt_next;
    logic [7:0]  held_reg [0:5];
    logic        active;
    logic        emit;
    logic [7:0]  emit_mask;

    assign active = in_valid && (pat_reg < pattern_count);

    always_comb
    begin
        phase_next    = phase_reg;
        rows_next     = rows_reg;
        row_next      = row_reg;
        pat_next      = pat_reg;
        mask_next     = mask_reg;
        held_cnt_next = held_cnt_reg;
        emit          = 1'b0;
        emit_mask     = mask_reg;
        if (active)
        begin
            case (phase_reg)
                PH_HDR0: phase_next = PH_HDR1;
                PH_HDR1: phase_next = PH_HDR2;
                PH_HDR2:
                begin
                    rows_next  = {8'd0, data_byte};
                    phase_next = PH_HDR3;
                end
                PH_HDR3:
                begin
                    rows_next = {data_byte, rows_reg[7:0]};
                    row_next  = 16'd0;
                    if ({data_byte, rows_reg[7:0]} == 16'd0)
                    begin
                        pat_next   = pat_reg + 16'd1;
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        phase_next    = PH_BODY;
                        held_cnt_next = 3'd0;
                    end
                end
                PH_BODY:
                begin
                    if (held_cnt_reg == 3'd0)
                    begin
                        if (data_byte == 8'd0)
                        begin
                            row_next = row_reg + 16'd1;
                            if ((row_reg + 16'd1) >= rows_reg)
                            begin
                                pat_next   = pat_reg + 16'd1;
                                row_next   = 16'd0;
                                phase_next = PH_HDR0;
                            end
                        end
                        else
                        begin
                            mask_next = data_byte;
                            emit_mask = data_byte;
                            if (payload_len(data_byte) == 3'd0) emit = 1'b1;
                            else held_cnt_next = 3'd1;
                        end
                    end
                    else if (held_cnt_reg >= payload_len(mask_reg))
                    begin
                        emit          = 1'b1;
                        held_cnt_next = 3'd0;
                    end
                    else
                    begin
                        held_cnt_next = held_cnt_reg + 3'd1;
                    end
                end
                default: phase_next = PH_HDR0;
            endcase
        end
    end

    // Hold each payload byte in its slot; slot is count minus one
    always_ff @(posedge clk)
    begin
        if (active && phase_reg == PH_BODY && held_cnt_reg != 3'd0)
            held_reg[held_cnt_reg - 3'd1] <= data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            rows_reg     <= 16'd0;
            row_reg      <= 16'd0;
            pat_reg      <= 16'd0;
            mask_reg     <= 8'd0;
            held_cnt_reg <= 3'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            rows_reg     <= rows_next;
            row_reg      <= row_next;
            pat_reg      <= pat_next;
            mask_reg     <= mask_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

    // Drop disabled channels here so they never take queue space
    always_comb
    begin
        entry_valid         = emit && !disabled_channel_mask[emit_mask[4:0]];
        entry.pattern_index = pat_reg;
        entry.row_index     = row_reg;
        entry.mask          = emit_mask;
        entry.b0            = held_reg[0];
        entry.b1            = held_reg[1];
        entry.b2            = held_reg[2];
        entry.b3            = held_reg[3];
        entry.b4            = held_reg[4];
        entry.b5            = held_reg[5];
        // The last payload byte is still on the input
        case (held_cnt_reg)
            3'd1: entry.b0 = data_byte;
            3'd2: entry.b1 = data_byte;
            3'd3: entry.b2 = data_byte;
            3'd4: entry.b3 = data_byte;
            3'd5: entry.b4 = data_byte;
            3'd6: entry.b5 = data_byte;
            default: ;
        endcase
    end

endmodule

### src/tpsd_queue.sv
// Short entry queue between the front end and the translation stage.
module tpsd_queue
    import tpsd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  entry_t wr_data,
    output logic   full,
    output logic   not_empty,
    input  logic   rd_en,
    output entry_t rd_data
);

    entry_t            mem_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full      = (count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en || rd_en) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> not_empty) else $error("queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("count did not advance");
`endif

endmodule

### src/tpsd_back.sv
// Back end: translates an entry into a cell record and holds it for transfer.
module tpsd_back
    import tpsd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   entry_valid,
    input  entry_t entry,
    output logic   entry_take,
    output logic   cell_valid,
    output cell_t  rec,
    input  logic   cell_take
);

    cell_t      cell_reg;
    logic       valid_reg;
    cell_t      c;
    logic [7:0] b [0:5];
    logic [7:0] cmd, prm, p, c1, d1, c2, d2, nb, hi, nn;
    logic [7:0] v;
    logic [1:0] vk;
    logic [7:0] vv;
    logic [4:0] code;
    logic [7:0] raw;
    logic [15:0] pan;
    logic       lost, two, one;
    logic [2:0] off;

    assign entry_take = entry_valid && (!valid_reg || cell_take);

    always_comb
    begin
        b[0] = entry.b0; b[1] = entry.b1; b[2] = entry.b2;
        b[3] = entry.b3; b[4] = entry.b4; b[5] = entry.b5;
        off  = entry.mask[5] ? 3'd2 : 3'd0;
        nb   = entry.b0;
        v    = {4'd0, nb[7:4]} * 8'd12 + {4'd0, nb[3:0]} + 8'd13;
        two  = entry.mask[7] && entry.mask[6];
        one  = entry.mask[7] ^ entry.mask[6];
        c1 = b[off]; d1 = b[off + 3'd1];
        c2 = entry.mask[5] ? entry.b4 : entry.b2;
        d2 = entry.mask[5] ? entry.b5 : entry.b3;
        vk = 2'd0; vv = 8'd0; cmd = 8'd0; prm = 8'd0; lost = 1'b0;
        pan = 16'd0;
        if (two)
        begin
            if (c1 == CMD_SET_VOL)
            begin
                vk = 2'd1; vv = (d1 > 8'h40) ? 8'h40 : d1; cmd = c2; prm = d2;
            end
            else if (c2 == CMD_SET_VOL)
            begin
                vk = 2'd1; vv = (d2 > 8'h40) ? 8'h40 : d2; cmd = c1; prm = d1;
            end
            else if (c1 == CMD_PAN || c2 == CMD_PAN)
            begin
                // d*64/255 via reciprocal: with p = d*64, (p + (p >> 8) + 1) >> 8 matches for 8-bit d
                pan = (c1 == CMD_PAN) ? {8'd0, d1} : {8'd0, d2};
                pan = pan << 6;
                vk  = 2'd2;
                vv  = 8'((pan + (pan >> 8) + 16'd1) >> 8);
                if (c1 == CMD_PAN)
                begin
                    cmd = c2; prm = d2;
                end
                else
                begin
                    cmd = c1; prm = d1;
                end
            end
            else
            begin
                lost = 1'b1; cmd = c2; prm = d2;
            end
        end
        else if (one)
        begin
            cmd = c1; prm = d1;
        end
        raw = cmd;
        p   = prm;
        hi  = {4'd0, prm[7:4]};
        nn  = 8'd0;
        case (cmd)
            CMD_SPEED_EXT:
            begin
                if (prm == 8'h00) p = prm;
                else if (prm == 8'hf0) p = 8'hef;
                else if (prm == 8'h0f) p = 8'hfe;
                else if (prm[7:4] != 4'd0) p = prm | 8'h0f;
                else p = prm | 8'hf0;
            end
            CMD_SET_TEMPO: p = 8'h20 | hi;
            CMD_NSLIDE_UP, CMD_NSLIDE_DN:
                p = (hi != 8'd0) ? (8'hf0 | hi) : (prm | 8'he0);
            CMD_HALVE: p = prm >> 1;
            CMD_SAMPLE_OFS: if (prm == 8'd0) raw = 8'd0;
            CMD_DOUBLE: p = prm[7] ? 8'd255 : {prm[6:0], 1'b0};
            CMD_EXTENDED:
            begin
                case (prm[7:4])
                    4'h0, 4'hc, 4'hd: ;
                    4'h3: nn = 8'h20;
                    4'h5: nn = 8'h30;
                    4'h8: nn = 8'h40;
                    4'ha: nn = 8'hb0;
                    4'hb: nn = 8'he0;
                    4'he: p = 8'h77;
                    default: raw = 8'd0;
                endcase
                if (nn != 8'd0) p = nn | {4'd0, prm[3:0]};
            end
            default: ;
        endcase
        code = (cmd != 8'd0) ? dense_code(raw) : 5'd0;
        if (code == CODE_SET_VOLUME && vk == 2'd0)
        begin
            vk = 2'd1; vv = p; code = 5'd0;
        end
        if (code == 5'd0) p = 8'd0;
        if (vk == 2'd0) vv = 8'd0;

        c.pattern_index     = entry.pattern_index;
        c.row_index         = entry.row_index;
        c.channel_index     = entry.mask[4:0];
        c.note_code         = 7'd0;
        c.instrument_number = 8'd0;
        if (entry.mask[5])
        begin
            c.instrument_number = entry.b1;
            if (nb == 8'd160) c.note_code = KEY_OFF_CODE;
            else if (nb == 8'd255) c.note_code = 7'd0;
            else if (v > 8'(HighestNote)) c.note_code = 7'd0;
            else c.note_code = v[6:0];
        end
        c.volume_kind    = vk;
        c.volume_value   = vv;
        c.effect_code    = code;
        c.effect_param   = p;
        c.effect_dropped = lost;
    end

    always_ff @(posedge clk)
    begin
        if (entry_take) cell_reg <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (entry_take) valid_reg <= 1'b1;
        else if (cell_take) valid_reg <= 1'b0;
    end

    assign cell_valid = valid_reg;
    assign rec        = cell_reg;

endmodule

### src/tracker_pattern_stream_decoder_unit.sv
// The entry that a byte completes is written into the queue; its cell is then registered in the back end.
// Throughput: one byte per cycle while full is low; one cell record per cycle while pop is held and entries wait.
// Input full rises when the four-entry queue between front and back is full.
// The front-end parser handles each input byte as it arrives; nothing iterates.
// Reset (rst_n low, asynchronous) clears parser, queue, output and registers.
// Top level: configuration registers, front-end parser, queue and back end.
module tracker_pattern_stream_decoder_unit
    import tpsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] pattern_index,
    output logic [15:0] row_index,
    output logic [4:0]  channel_index,
    output logic [6:0]  note_code,
    output logic [7:0]  instrument_number,
    output logic [1:0]  volume_kind,
    output logic [7:0]  volume_value,
    output logic [4:0]  effect_code,
    output logic [7:0]  effect_param,
    output logic        effect_dropped,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0] pattern_count_reg;
    logic [31:0] disabled_mask_reg;
    logic        in_valid, entry_valid, q_full, q_ne, q_take, cell_valid;
    entry_t      entry, q_entry;
    cell_t       rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_count_reg <= 16'd0;
            disabled_mask_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_COUNT: pattern_count_reg <= cfg_data[15:0];
                CFG_DISABLED_MASK: disabled_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign full     = q_full;
    assign in_valid = push && !q_full;

    tpsd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .data_byte(data_byte),
        .pattern_count(pattern_count_reg), .disabled_channel_mask(disabled_mask_reg),
        .entry_valid(entry_valid), .entry(entry)
    );

    tpsd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(entry_valid), .wr_data(entry),
        .full(q_full), .not_empty(q_ne), .rd_en(q_take), .rd_data(q_entry)
    );

    tpsd_back u_back (
        .clk(clk), .rst_n(rst_n), .entry_valid(q_ne), .entry(q_entry),
        .entry_take(q_take), .cell_valid(cell_valid), .rec(rec),
        .cell_take(pop && cell_valid)
    );

    assign empty             = !cell_valid;
    assign pattern_index     = rec.pattern_index;
    assign row_index         = rec.row_index;
    assign channel_index     = rec.channel_index;
    assign note_code         = rec.note_code;
    assign instrument_number = rec.instrument_number;
    assign volume_kind       = rec.volume_kind;
    assign volume_value      = rec.volume_value;
    assign effect_code       = rec.effect_code;
    assign effect_param      = rec.effect_param;
    assign effect_dropped    = rec.effect_dropped;

endmodule

### verif/tb_tracker_pattern_stream_decoder_unit.sv
// Testbench for the pattern stream decoder: byte stimulus, cell prediction and scoreboard.
`timescale 1ns / 1ps

class cell_scoreboard;
    tpsd_pkg::cell_t pending_cells[$];
    int mismatches;
    int cells_checked;

    function void note_cell(tpsd_pkg::cell_t c);
        pending_cells.push_back(c);
    endfunction

    function int check_cell(tpsd_pkg::cell_t got, output string why);
        tpsd_pkg::cell_t want;
        why = "";
        if (pending_cells.size() == 0)
        begin
            why = "cell with none pending";
            return 0;
        end
        want = pending_cells.pop_front();
        cells_checked++;
        if (got.pattern_index != want.pattern_index) why = {why, " pattern_index"};
        if (got.row_index != want.row_index) why = {why, " row_index"};
        if (got.channel_index != want.channel_index) why = {why, " channel_index"};
        if (got.note_code != want.note_code) why = {why, " note_code"};
        if (got.instrument_number != want.instrument_number) why = {why, " instrument"};
        if (got.volume_kind != want.volume_kind) why = {why, " volume_kind"};
        if (got.volume_value != want.volume_value) why = {why, " volume_value"};
        if (got.effect_code != want.effect_code) why = {why, " effect_code"};
        if (got.effect_param != want.effect_param) why = {why, " effect_param"};
        if (got.effect_dropped != want.effect_dropped) why = {why, " effect_dropped"};
        if (why != "")
        begin
            why = $sformatf("got %h want %h:%s", got, want, why);
            return 0;
        end
        return 1;
    endfunction
endclass

module tb_tracker_pattern_stream_decoder_unit;
    import tpsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic [15:0] pattern_index;
    logic [15:0] row_index;
    logic [4:0]  channel_index;
    logic [6:0]  note_code;
    logic [7:0]  instrument_number;
    logic [1:0]  volume_kind;
    logic [7:0]  volume_value;
    logic [4:0]  effect_code;
    logic [7:0]  effect_param;
    logic        effect_dropped;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    tracker_pattern_stream_decoder_unit u_top (.*);

    cell_scoreboard board;
    int errors;
    int bytes_sent;
    int idle_cycles;
    bit hold_off;
    bit stim_done;
    bit drain_done;

    // predictor state
    logic [15:0] pat_total;
    logic [31:0] chan_off;
    int          phase;
    logic [15:0] row_total;
    logic [15:0] row_now;
    logic [15:0] pat_now;
    logic [7:0]  mask_now;
    logic [7:0]  held[6];

    initial begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    task automatic report(string msg);
        errors++;
        $display("MISMATCH: %s", msg);
    endtask

    function automatic int entry_bytes(logic [7:0] m);
        int n;
        n = m[5] ? 2 : 0;
        if (m[7] && m[6]) n += 4;
        else if (m[7] || m[6]) n += 2;
        return n;
    endfunction

    function automatic logic [4:0] remap_code(logic [7:0] raw);
        logic [4:0] t[36] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 13, 14,
            15, 16, 17, 18, 17, 18, 19, 0, 20, 0, 21, 22, 23, 24, 25, 26, 27, 14, 0, 0};
        return (raw < 36) ? t[raw] : 5'd0;
    endfunction

    function automatic void predict_cell();
        cell_t c;
        int off, note, p, hi, n, vk, vv, code, lost, b, v;
        int cmd, prm;
        int c1, d1, c2, d2;
        logic [4:0] ch;
        ch = mask_now[4:0];
        off = 0; note = 0; vk = 0; vv = 0; cmd = 0; prm = 0; lost = 0; code = 0;
        c = '0;
        if (chan_off[ch]) return;
        if (mask_now[5])
        begin
            b = held[0];
            c.instrument_number = held[1];
            off = 2;
            if (b == 160) note = KEY_OFF_CODE;
            else if (b == 255) note = 0;
            else
            begin
                v = (b >> 4) * 12 + (b & 15) + 13;
                note = (v > HighestNote) ? 0 : v;
            end
        end
        if (mask_now[7] && mask_now[6])
        begin
            c1 = held[off]; d1 = held[off + 1]; c2 = held[off + 2]; d2 = held[off + 3];
            if (c1 == CMD_SET_VOL)
            begin vk = 1; vv = d1 > 64 ? 64 : d1; cmd = c2; prm = d2; end
            else if (c2 == CMD_SET_VOL)
            begin vk = 1; vv = d2 > 64 ? 64 : d2; cmd = c1; prm = d1; end
            else if (c1 == CMD_PAN)
            begin vk = 2; vv = d1 * 64 / 255; cmd = c2; prm = d2; end
            else if (c2 == CMD_PAN)
            begin vk = 2; vv = d2 * 64 / 255; cmd = c1; prm = d1; end
            else
            begin lost = 1; cmd = c2; prm = d2; end
        end
        else if (mask_now[7] || mask_now[6])
        begin
            cmd = held[off]; prm = held[off + 1];
        end
        if (cmd != 0)
        begin
            p = prm; hi = p >> 4; n = 0;
            case (cmd)
                CMD_SPEED_EXT:
                    if (p == 0) ;
                    else if (p == 8'hf0) p = 8'hef;
                    else if (p == 8'h0f) p = 8'hfe;
                    else if (p & 8'hf0) p |= 8'h0f;
                    else p |= 8'hf0;
                CMD_SET_TEMPO: p = 8'h20 | hi;
                CMD_NSLIDE_UP, CMD_NSLIDE_DN: p = hi ? (8'hf0 | hi) : (p | 8'he0);
                CMD_HALVE: p >>= 1;
                CMD_SAMPLE_OFS: if (p == 0) cmd = 0;
                CMD_DOUBLE: p = (p << 1) > 255 ? 255 : (p << 1);
                CMD_EXTENDED:
                begin
                    case (hi)
                        0, 12, 13: ;
                        3: n = 8'h20;
                        5: n = 8'h30;
                        8: n = 8'h40;
                        10: n = 8'hb0;
                        11: n = 8'he0;
                        14: p = 8'h77;
                        default: cmd = 0;
                    endcase
                    if (n != 0) p = n | (p & 15);
                end
                default: ;
            endcase
            code = remap_code(cmd[7:0]);
            if (code == CODE_SET_VOLUME && vk == 0)
            begin
                vk = 1; vv = p; code = 0; p = 0;
            end
            prm = p & 255;
        end
        if (code == 0) prm = 0;
        if (vk == 0) vv = 0;
        c.pattern_index = pat_now;
        c.row_index = row_now;
        c.channel_index = ch;
        c.note_code = note[6:0];
        c.volume_kind = vk[1:0];
        c.volume_value = vv[7:0];
        c.effect_code = code[4:0];
        c.effect_param = prm[7:0];
        c.effect_dropped = lost[0];
        board.note_cell(c);
    endfunction

    function automatic void end_pattern();
        pat_now = pat_now + 16'd1;
        row_now = 0;
        phase = 0;
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int k;
        if (pat_now >= pat_total) return;
        case (phase)
            0, 1: phase++;
            2:
            begin
                row_total = {8'h00, b};
                phase = 3;
            end
            3:
            begin
                row_total[15:8] = b;
                row_now = 0;
                if (row_total == 0) end_pattern();
                else phase = 4;
            end
            4:
            begin
                if (b == 0)
                begin
                    row_now = row_now + 16'd1;
                    if (row_now >= row_total) end_pattern();
                end
                else
                begin
                    mask_now = b;
                    if (entry_bytes(b) == 0) predict_cell();
                    else phase = 5;
                end
            end
            default:
            begin
                k = phase - 5;
                held[k] = b;
                if (k + 1 >= entry_bytes(mask_now))
                begin
                    phase = 4;
                    predict_cell();
                end
                else phase++;
            end
        endcase
    endfunction

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        push <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PATTERN_COUNT) pat_total = val[15:0];
        else chan_off = val;
        @(posedge clk);
    endtask

    // drain before reconfiguring
    task automatic wait_idle();
        push <= 1'b0;
        while (board.pending_cells.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic send_entry();
        logic [7:0] m;
        int i;
        int kind;
        m = $urandom_range(1, 255);
        if (m[4:0] == 0 && m[7:5] == 0) m = 8'h01;
        send_byte(m);
        for (i = 0; i < entry_bytes(m); i++)
        begin
            kind = $urandom_range(0, 5);
            // command bytes mostly from the known set
            if (m[5] && i == 0 && kind < 2) send_byte(kind ? 8'd160 : 8'd255);
            else if (((m[5] && i >= 2) || (!m[5])) && ((i - (m[5] ? 2 : 0)) % 2 == 0)
                     && kind < 5)
                send_byte($urandom_range(0, 8'h23));
            else send_byte($urandom_range(0, 255));
        end
    endtask

    task automatic send_pattern(int rows, int per_row);
        int r, e;
        send_byte($urandom_range(0, 255));
        send_byte($urandom_range(0, 255));
        send_byte(rows[7:0]);
        send_byte(rows[15:8]);
        for (r = 0; r < rows; r++)
        begin
            for (e = 0; e < $urandom_range(0, per_row); e++) send_entry();
            send_byte(8'h00);
        end
    endtask

    initial begin
        int i;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        data_byte = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        board = new();
        pat_total = 0; chan_off = 0; phase = 0; row_total = 0;
        row_now = 0; pat_now = 0; mask_now = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes ignored while no patterns are configured
        send_byte(8'hff);
        send_byte(8'h21);
        write_reg(CFG_PATTERN_COUNT, 32'd3);
        write_reg(CFG_DISABLED_MASK, 32'h0000_0000);
        // directed pattern: zero-row header then a two-row pattern of edge entries
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h02); send_byte(8'h00);
        send_byte(8'h1f);
        send_byte(8'h21); send_byte(8'd160); send_byte(8'hff);
        send_byte(8'h23); send_byte(8'd255); send_byte(8'h00);
        send_byte(8'h24); send_byte(8'h99); send_byte(8'h07);
        send_byte(8'h45); send_byte(8'h18); send_byte(8'h00);
        send_byte(8'h86); send_byte(8'h0c); send_byte(8'hff);
        send_byte(8'hc7); send_byte(8'h0c); send_byte(8'h50);
        send_byte(8'h0c); send_byte(8'h10);
        send_byte(8'hc8); send_byte(8'h01); send_byte(8'h02);
        send_byte(8'h0a); send_byte(8'hff);
        send_byte(8'hc9); send_byte(8'h30); send_byte(8'h02);
        send_byte(8'hff); send_byte(8'h21);
        send_byte(8'h00);
        send_byte(8'h00);
        wait_idle();

        for (i = 0; i < 6; i++)
        begin
            case (i)
                0: write_reg(CFG_DISABLED_MASK, 32'hffff_ffff);
                1: write_reg(CFG_DISABLED_MASK, 32'h0000_0000);
                default: write_reg(CFG_DISABLED_MASK, $urandom() & $urandom());
            endcase
            // the pattern position runs on, so each new count lies above it
            write_reg(CFG_PATTERN_COUNT, (i == 5) ? 32'd65535 :
                      {16'd0, pat_now} + 32'($urandom_range(1, 4)));
            if (i == 5) hold_off = 1'b1;
            while (pat_now < pat_total && bytes_sent < 220 * (i + 1) + 60)
                send_pattern($urandom_range(0, 6), 4);
            // noise bytes: ignored once the count is reached, else random stream
            repeat (10) send_byte($urandom_range(0, 255));
            wait_idle();
        end
        stim_done = 1'b1;
    end

    initial begin
        int gap;
        string why;
        cell_t got;
        wait (rst_n);
        forever
        begin
            if (hold_off)
            begin
                pop <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            got = '{pattern_index, row_index, channel_index, note_code, instrument_number,
                    volume_kind, volume_value, effect_code, effect_param, effect_dropped};
            if (!board.check_cell(got, why)) report(why);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("tb_tracker_pattern_stream_decoder_unit: done, errors");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        repeat (20) @(posedge clk);
        if (board.pending_cells.size() != 0) report("cells left unmatched at end");
        $display("Covered %0d bytes and %0d cells over several mask and count settings.",
                 bytes_sent, board.cells_checked);
        if (errors == 0)
            $display("tb_tracker_pattern_stream_decoder_unit: done, clean");
        else
            $display("tb_tracker_pattern_stream_decoder_unit: done, errors");
        $finish;
    end
endmodule
